[hdl/vqdm_pkg.sv]
package vqdm_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] seg_addr;
    logic [31:0] seg_len;
    logic [8:0]  out_count;
    logic [8:0]  in_count;
    logic [15:0] device_used_idx;
    logic [7:0]  used_id;
    logic [31:0] used_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  head_index;
    logic [31:0] completed_len;
    logic [15:0] notify_queue;
    logic [8:0]  free_count;
  } out_item_t;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_RECLAIM = 2'd1;
  localparam logic [1:0] KIND_KICK    = 2'd2;

  localparam logic [2:0] ST_TAKEN    = 3'd0;
  localparam logic [2:0] ST_POSTED   = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_RECLAIM  = 3'd4;
  localparam logic [2:0] ST_NOTIFY   = 3'd5;

  localparam logic [1:0] FLAG_NEXT  = 2'b01;
  localparam logic [1:0] FLAG_WRITE = 2'b10;

  localparam logic [2:0] REG_ENTRIES = 3'd0;
  localparam logic [2:0] REG_QNUM    = 3'd1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ADD,
    S_LINK,
    S_WALK_RD,
    S_WALK,
    S_OUT
  } state_t;

endpackage

[hdl/vqdm_ram.sv]
module vqdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/virtqueue_descriptor_manager_top.sv]
// Driver side of a split virtqueue: descriptor table, free list and
// available ring held on chip.
// in_ channel: one item per transfer (add segment, reclaim, kick).
// out_ channel: one result per transfer; kind 3 is dropped with no result.
// cfg_ port: APB-style, reg 0 queue_entries at 0x0, reg 1 queue_number at 0x4.
// An add that links to an earlier segment passes the add, link and output
// states before its result; a first segment or a rejected one skips the
// link state. The free-head read and the read-modify-write of the previous
// descriptor share the link/flag table; the descriptor write goes to its own
// table. Reclaim reads then writes back each freed descriptor in turn (read
// then write-back of each chain entry through the link/flag memory); a
// reclaim with nothing used goes from the read state to output. Kick goes
// straight to the output state. in_ready is high only in the idle state
// with no held result, so a new item is not taken until the last is done.
// Reset, and every write of queue_entries, runs a rebuild pass over every
// effective entry that rewrites links and clears flags; no item is taken
// meanwhile. A held result waits in the output register while out_ready is
// low; the block does not take the next item until the result transfers.
module virtqueue_descriptor_manager_top #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vqdm_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vqdm_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [15:0] LINK_END = 16'hFFFF;

  vqdm_pkg::state_t state_r, state_nxt;

  logic [8:0]  qent_r;
  logic [15:0] qnum_r;
  logic [CW-1:0] n_eff;
  logic [AW-1:0] mask;

  logic [15:0] avail_idx_r, avail_idx_nxt;
  logic [AW-1:0] fhead_r, fhead_nxt;
  logic [CW-1:0] ftotal_r, ftotal_nxt;
  logic [15:0] used_seen_r, used_seen_nxt;
  logic [8:0]  segpos_r, segpos_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] rhead_r, rhead_nxt;
  logic        rej_r, rej_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  vqdm_pkg::in_item_t item_r, item_nxt;
  vqdm_pkg::out_item_t res_r, res_nxt;
  logic        ov_r, ov_nxt;
  logic        add_wr_r, add_wr_nxt;

  // link/flag table: one port shared over the sequence
  logic          lf_we;
  logic [AW-1:0] lf_waddr, lf_raddr;
  logic [17:0]   lf_wdata, lf_rdata;
  logic          da_we;
  logic [AW-1:0] da_addr;
  logic          av_we;
  logic [7:0]    av_unused;
  logic [95:0]   da_unused;

  vqdm_ram #(.WIDTH(18), .DEPTH(QUEUE_DEPTH)) u_link (
    .clk(clk), .we(lf_we), .waddr(lf_waddr), .wdata(lf_wdata),
    .raddr(lf_raddr), .rdata(lf_rdata)
  );
  vqdm_ram #(.WIDTH(96), .DEPTH(QUEUE_DEPTH)) u_desc (
    .clk(clk), .we(da_we), .waddr(da_addr),
    .wdata({item_r.seg_addr, item_r.seg_len}), .raddr(da_addr), .rdata(da_unused)
  );
  vqdm_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_avail (
    .clk(clk), .we(av_we), .waddr(avail_idx_r[AW-1:0] & mask),
    .wdata(8'(rhead_nxt)), .raddr(avail_idx_r[AW-1:0]), .rdata(av_unused)
  );

  // effective entries: round down to a power of two, clamp 2..QUEUE_DEPTH
  always_comb begin
    n_eff = CW'(2);
    for (int k = 2; k <= CW - 1; k++) begin
      if (32'(qent_r) >= (32'd1 << k)) begin
        n_eff = CW'(32'd1 << k);
      end
    end
  end
  assign mask = AW'(n_eff - CW'(1));

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr)
      {vqdm_pkg::REG_ENTRIES[0], 2'b00}: cfg_prdata = {23'd0, qent_r};
      {vqdm_pkg::REG_QNUM[0], 2'b00}:    cfg_prdata = {16'd0, qnum_r};
      default:                           cfg_prdata = 32'd0;
    endcase
  end

  logic rebuild;
  assign rebuild = cfg_wr && (cfg_paddr == {vqdm_pkg::REG_ENTRIES[0], 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qent_r <= 9'd256;
      qnum_r <= 16'd0;
    end else if (cfg_wr) begin
      if (cfg_paddr == {vqdm_pkg::REG_ENTRIES[0], 2'b00}) begin
        qent_r <= cfg_pwdata[8:0];
      end else if (cfg_paddr == {vqdm_pkg::REG_QNUM[0], 2'b00}) begin
        qnum_r <= cfg_pwdata[15:0];
      end
    end
  end

  logic [9:0] total;
  logic       bad, last, more;
  logic [AW-1:0] cur_idx, nxt_link;
  assign total = 10'(item_r.out_count) + 10'(item_r.in_count);
  assign last  = (10'(segpos_r) + 10'd1) >= total;
  assign cur_idx = fhead_r & mask;
  assign nxt_link = lf_rdata[AW-1:0] & mask;
  assign more = lf_rdata[16];
  always_comb begin
    if (segpos_r == 9'd0) begin
      bad = (total == 10'd0) || (10'(ftotal_r) > 10'd0 && total > 10'(ftotal_r))
            || (ftotal_r == CW'(0));
    end else begin
      bad = rej_r || (ftotal_r == CW'(0));
    end
  end

  assign in_ready = (state_r == vqdm_pkg::S_IDLE) && !ov_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vqdm_pkg::S_INIT:    if (cnt_r == mask) state_nxt = vqdm_pkg::S_IDLE;
      vqdm_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (in_data.kind)
            vqdm_pkg::KIND_ADD:     state_nxt = vqdm_pkg::S_ADD;
            vqdm_pkg::KIND_RECLAIM: state_nxt = vqdm_pkg::S_WALK_RD;
            vqdm_pkg::KIND_KICK:    state_nxt = vqdm_pkg::S_OUT;
            default:                state_nxt = vqdm_pkg::S_IDLE;
          endcase
        end
      end
      vqdm_pkg::S_ADD:     state_nxt = (bad || segpos_r == 9'd0) ? vqdm_pkg::S_OUT
                                                                  : vqdm_pkg::S_LINK;
      vqdm_pkg::S_LINK:    state_nxt = vqdm_pkg::S_OUT;
      vqdm_pkg::S_WALK_RD: state_nxt = (item_r.device_used_idx == used_seen_r)
                                       ? vqdm_pkg::S_OUT : vqdm_pkg::S_WALK;
      vqdm_pkg::S_WALK:    if (!more || steps_r + CW'(1) >= n_eff)
                             state_nxt = vqdm_pkg::S_OUT;
                           else state_nxt = vqdm_pkg::S_WALK_RD;
      vqdm_pkg::S_OUT:     state_nxt = vqdm_pkg::S_IDLE;
      default:             state_nxt = vqdm_pkg::S_IDLE;
    endcase
    if (rebuild) state_nxt = vqdm_pkg::S_INIT;
  end

  // datapath and table control
  always_comb begin
    avail_idx_nxt = avail_idx_r;
    fhead_nxt = fhead_r;
    ftotal_nxt = ftotal_r;
    used_seen_nxt = used_seen_r;
    segpos_nxt = segpos_r;
    prev_nxt = prev_r;
    rhead_nxt = rhead_r;
    rej_nxt = rej_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    steps_nxt = steps_r;
    item_nxt = item_r;
    res_nxt = res_r;
    add_wr_nxt = add_wr_r;
    ov_nxt = ov_r && !out_ready;
    lf_we = 1'b0;
    lf_waddr = cnt_r;
    lf_wdata = 18'd0;
    lf_raddr = cur_idx;
    da_we = 1'b0;
    da_addr = cur_idx;
    av_we = 1'b0;
    unique case (state_r)
      vqdm_pkg::S_INIT: begin
        lf_we = 1'b1;
        lf_waddr = cnt_r;
        lf_wdata = {2'b00, (cnt_r == mask) ? LINK_END : 16'(cnt_r) + 16'd1};
        cnt_nxt = cnt_r + AW'(1);
        ftotal_nxt = n_eff;
      end
      vqdm_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt = in_data;
          idx_nxt = AW'(in_data.used_id) & mask;
          steps_nxt = CW'(0);
          res_nxt = '0;
          res_nxt.free_count = 9'(ftotal_r);
        end
      end
      vqdm_pkg::S_ADD: begin
        // link memory read of the free head is valid now; fetch prev for the link step
        lf_raddr = prev_r & mask;
        if (bad) begin
          res_nxt.status = vqdm_pkg::ST_REJECTED;
          if (last) begin
            rej_nxt = 1'b0;
            segpos_nxt = 9'd0;
          end else begin
            rej_nxt = 1'b1;
            segpos_nxt = segpos_r + 9'd1;
          end
        end else begin
          fhead_nxt = nxt_link;
          ftotal_nxt = ftotal_r - CW'(1);
          da_we = 1'b1;
          lf_we = 1'b1;
          lf_waddr = cur_idx;
          add_wr_nxt = (segpos_r >= item_r.out_count);
          // link left as it was; only the flags are replaced
          lf_wdata = {(segpos_r >= item_r.out_count) ? vqdm_pkg::FLAG_WRITE : 2'b00,
                      lf_rdata[15:0]};
          if (segpos_r == 9'd0) rhead_nxt = cur_idx;
          prev_nxt = cur_idx;
          idx_nxt = prev_r & mask;
          res_nxt.head_index = 8'((segpos_r == 9'd0) ? cur_idx : rhead_r);
          res_nxt.free_count = 9'(ftotal_r - CW'(1));
          if (last) begin
            av_we = 1'b1;
            avail_idx_nxt = avail_idx_r + 16'd1;
            segpos_nxt = 9'd0;
            res_nxt.status = vqdm_pkg::ST_POSTED;
          end else begin
            segpos_nxt = segpos_r + 9'd1;
            res_nxt.status = vqdm_pkg::ST_TAKEN;
          end
        end
      end
      vqdm_pkg::S_LINK: begin
        // previous descriptor gains NEXT and the new link; its WRITE flag is kept,
        // taken from the add just done when it is the same descriptor
        lf_raddr = idx_r;
        lf_we = 1'b1;
        lf_waddr = idx_r;
        lf_wdata = {(idx_r == prev_r) ? add_wr_r : lf_rdata[17], 1'b1, 16'(prev_r)};
      end
      vqdm_pkg::S_WALK_RD: begin
        lf_raddr = idx_r;
        if (item_r.device_used_idx == used_seen_r) begin
          res_nxt.status = vqdm_pkg::ST_NONE;
        end
      end
      vqdm_pkg::S_WALK: begin
        lf_raddr = idx_r;
        lf_we = 1'b1;
        lf_waddr = idx_r;
        lf_wdata = {2'b00, 16'(fhead_r)};
        fhead_nxt = idx_r;
        if (ftotal_r < n_eff) ftotal_nxt = ftotal_r + CW'(1);
        idx_nxt = nxt_link;
        steps_nxt = steps_r + CW'(1);
        if (!more || steps_r + CW'(1) >= n_eff) begin
          used_seen_nxt = used_seen_r + 16'd1;
          res_nxt.status = vqdm_pkg::ST_RECLAIM;
          res_nxt.head_index = 8'(AW'(item_r.used_id) & mask);
          res_nxt.completed_len = item_r.used_len;
          res_nxt.free_count = 9'((ftotal_r < n_eff) ? ftotal_r + CW'(1) : ftotal_r);
        end
      end
      vqdm_pkg::S_OUT: begin
        if (item_r.kind == vqdm_pkg::KIND_KICK) begin
          res_nxt.status = vqdm_pkg::ST_NOTIFY;
          res_nxt.notify_queue = qnum_r;
        end
        ov_nxt = 1'b1;
      end
      default: ;
    endcase
    if (rebuild) begin
      cnt_nxt = AW'(0);
      fhead_nxt = AW'(0);
      ftotal_nxt = n_eff;
      avail_idx_nxt = 16'd0;
      used_seen_nxt = 16'd0;
      segpos_nxt = 9'd0;
      prev_nxt = AW'(0);
      rhead_nxt = AW'(0);
      rej_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vqdm_pkg::S_INIT;
      avail_idx_r <= 16'd0;
      fhead_r <= AW'(0);
      ftotal_r <= CW'(QUEUE_DEPTH);
      used_seen_r <= 16'd0;
      segpos_r <= 9'd0;
      prev_r <= AW'(0);
      rhead_r <= AW'(0);
      rej_r <= 1'b0;
      cnt_r <= AW'(0);
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      avail_idx_r <= avail_idx_nxt;
      fhead_r <= fhead_nxt;
      ftotal_r <= ftotal_nxt;
      used_seen_r <= used_seen_nxt;
      segpos_r <= segpos_nxt;
      prev_r <= prev_nxt;
      rhead_r <= rhead_nxt;
      rej_r <= rej_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    steps_r <= steps_nxt;
    item_r <= item_nxt;
    res_r <= res_nxt;
    add_wr_r <= add_wr_nxt;
  end

  assign out_valid = ov_r;
  assign out_data = res_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == vqdm_pkg::S_IDLE) else $error("ready outside idle");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ftotal_r <= n_eff || state_r == vqdm_pkg::S_INIT) else $error("free count overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r) else $error("result dropped");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !in_ready) else $error("item taken over held result");

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] KIND_UNDEF = 2'd3;
  localparam int         WATCHDOG_LIMIT = 6000;
  localparam int         LONG_HOLD = 400;
  localparam int         SETTLE_CYCLES = 600;

  typedef struct {
    vqdm_pkg::in_item_t item;
    bit       auto_reclaim;  // fill used index/id from the posted heads at drive time
  } pending_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  vqdm_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_ready;
  vqdm_pkg::out_item_t out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  virtqueue_descriptor_manager_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // queue state as the block should hold it
  logic [15:0] q_link [256];
  logic [1:0]  q_flag [256];
  logic [7:0]  q_free_head;
  int          q_free_total;
  logic [15:0] q_used_seen;
  int          q_seg_pos;
  logic [7:0]  q_prev;
  logic [7:0]  q_req_head;
  bit          q_rejecting;
  logic [8:0]  q_entries_reg;
  logic [15:0] q_number;

  pending_t    pending_q[$];
  vqdm_pkg::out_item_t expected_q[$];
  logic [7:0]  posted_heads[$];

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_arm;
  bit          hold_seen;
  int          hold_cnt;
  int          errors;
  int          quiet_cycles;

  function automatic int eff_entries();
    int n;
    n = 2;
    while (n * 2 <= q_entries_reg && n * 2 <= 256) n = n * 2;
    return n;
  endfunction

  function automatic void rebuild_queue();
    int n;
    n = eff_entries();
    for (int i = 0; i < n; i++) begin
      q_link[i] = 16'(i + 1);
      q_flag[i] = 2'b00;
    end
    q_link[n-1] = 16'hFFFF;
    q_free_head = 0;
    q_free_total = n;
    q_used_seen = 0;
    q_seg_pos = 0;
    q_prev = 0;
    q_req_head = 0;
    q_rejecting = 0;
    posted_heads.delete();
  endfunction

  function automatic void reject_step(int total);
    if (q_seg_pos + 1 >= total) begin
      q_rejecting = 0;
      q_seg_pos = 0;
    end else begin
      q_rejecting = 1;
      q_seg_pos++;
    end
  endfunction

  function automatic void queue_step(input vqdm_pkg::in_item_t it);
    int        n, mask, total, idx, nxt, outc;
    bit        bad, more;
    vqdm_pkg::out_item_t r;
    n = eff_entries();
    mask = n - 1;
    r = '0;
    if (it.kind == KIND_UNDEF) return;
    if (it.kind == vqdm_pkg::KIND_ADD) begin
      outc = it.out_count;
      total = int'(it.out_count) + int'(it.in_count);
      if (q_seg_pos == 0) bad = (total == 0 || total > q_free_total);
      else bad = q_rejecting || q_free_total == 0;
      if (bad) begin
        r.status = vqdm_pkg::ST_REJECTED;
        reject_step(total);
      end else begin
        idx = q_free_head & mask;
        q_free_head = 8'(q_link[idx] & mask);
        q_free_total--;
        q_flag[idx] = (q_seg_pos >= outc) ? vqdm_pkg::FLAG_WRITE : 2'b00;
        if (q_seg_pos == 0) begin
          q_req_head = 8'(idx);
        end else begin
          q_flag[q_prev & mask] = q_flag[q_prev & mask] | vqdm_pkg::FLAG_NEXT;
          q_link[q_prev & mask] = 16'(idx);
        end
        q_prev = 8'(idx);
        r.head_index = q_req_head;
        if (q_seg_pos + 1 >= total) begin
          q_seg_pos = 0;
          r.status = vqdm_pkg::ST_POSTED;
          posted_heads.push_back(q_req_head);
        end else begin
          q_seg_pos++;
          r.status = vqdm_pkg::ST_TAKEN;
        end
      end
    end else if (it.kind == vqdm_pkg::KIND_RECLAIM) begin
      if (it.device_used_idx == q_used_seen) begin
        r.status = vqdm_pkg::ST_NONE;
      end else begin
        idx = it.used_id & mask;
        r.head_index = 8'(idx);
        r.completed_len = it.used_len;
        for (int s = 0; s < n; s++) begin
          nxt = q_link[idx] & mask;
          more = (q_flag[idx] & vqdm_pkg::FLAG_NEXT) != 0;
          q_flag[idx] = 2'b00;
          q_link[idx] = {8'h00, q_free_head};
          q_free_head = 8'(idx);
          if (q_free_total < n) q_free_total++;
          if (!more) break;
          idx = nxt;
        end
        q_used_seen = q_used_seen + 16'd1;
        r.status = vqdm_pkg::ST_RECLAIM;
      end
    end else begin
      r.status = vqdm_pkg::ST_NOTIFY;
      r.notify_queue = q_number;
    end
    r.free_count = 9'(q_free_total);
    expected_q.push_back(r);
  endfunction

  function automatic vqdm_pkg::in_item_t random_item();
    vqdm_pkg::in_item_t it;
    it.kind = 2'($urandom_range(3));
    it.seg_addr = {$urandom, $urandom};
    it.seg_len = $urandom;
    it.out_count = 9'($urandom);
    it.in_count = 9'($urandom);
    it.device_used_idx = 16'($urandom);
    it.used_id = 8'($urandom);
    it.used_len = $urandom;
    return it;
  endfunction

  function automatic void push_item(input vqdm_pkg::in_item_t it, input bit auto_rc);
    pending_t p;
    p.item = it;
    p.auto_reclaim = auto_rc;
    pending_q.push_back(p);
  endfunction

  function automatic void push_request(int outc, int inc, int segs);
    vqdm_pkg::in_item_t it;
    for (int s = 0; s < segs; s++) begin
      it = random_item();
      it.kind = vqdm_pkg::KIND_ADD;
      it.out_count = 9'(outc);
      it.in_count = 9'(inc);
      // now and then the counts shift mid-request
      if (s > 0 && $urandom_range(19) == 0) it.in_count = 9'(inc + 1);
      push_item(it, 0);
    end
  endfunction

  function automatic void push_reclaim();
    vqdm_pkg::in_item_t it;
    it = random_item();
    it.kind = vqdm_pkg::KIND_RECLAIM;
    push_item(it, 1);
  endfunction

  function automatic void push_random_mix(int count);
    int pick, total, outc;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        total = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(1, 4);
        outc = $urandom_range(total);
        push_request(outc, total - outc, (total == 0) ? 1 : total);
      end else if (pick < 88) begin
        push_reclaim();
      end else if (pick < 93) begin
        push_item('{kind: vqdm_pkg::KIND_KICK, default: '0}, 0);
      end else begin
        push_item(random_item(), 0);
      end
    end
  endfunction

  task automatic cfg_write(input logic [2:0] reg_idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(reg_idx * 4);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_idx == vqdm_pkg::REG_ENTRIES) begin
      q_entries_reg = value[8:0];
      rebuild_queue();
    end else begin
      q_number = value[15:0];
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver; prediction runs here too so that posted heads are current
  always @(posedge clk) begin
    pending_t p;
    if (in_valid && in_ready) queue_step(in_data);
    if (!in_valid || in_ready) begin
      if (rst_n && pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        p = pending_q.pop_front();
        if (p.auto_reclaim) begin
          if (posted_heads.size() != 0) begin
            p.item.used_id = posted_heads.pop_front();
            p.item.device_used_idx = q_used_seen + 16'd1;
          end else begin
            p.item.device_used_idx = q_used_seen;
          end
        end
        in_valid <= 1'b1;
        in_data <= p.item;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_cnt <= LONG_HOLD;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin
    vqdm_pkg::out_item_t e;
    out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_stall_pct);
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          errors++;
        end
        if (out_data.head_index !== e.head_index) begin
          $error("head_index: expected %0d, got %0d", e.head_index, out_data.head_index);
          errors++;
        end
        if (out_data.completed_len !== e.completed_len) begin
          $error("completed_len: expected %0h, got %0h", e.completed_len,
                 out_data.completed_len);
          errors++;
        end
        if (out_data.notify_queue !== e.notify_queue) begin
          $error("notify_queue: expected %0h, got %0h", e.notify_queue,
                 out_data.notify_queue);
          errors++;
        end
        if (out_data.free_count !== e.free_count) begin
          $error("free_count: expected %0d, got %0d", e.free_count, out_data.free_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    vqdm_pkg::in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_arm = 0;
    hold_seen = 0;
    hold_cnt = 0;
    errors = 0;
    quiet_cycles = 0;
    q_entries_reg = 9'd256;
    q_number = 16'd0;
    rebuild_queue();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, bad sizes, empty reclaim, kick, undefined kind
    it = '{kind: vqdm_pkg::KIND_ADD, seg_addr: '1, seg_len: '1, out_count: 9'd1,
           in_count: 9'd0, default: '0};
    push_item(it, 0);
    it = '{kind: vqdm_pkg::KIND_ADD, out_count: 9'd0, in_count: 9'd0, default: '0};
    push_item(it, 0);
    it = '{kind: vqdm_pkg::KIND_ADD, out_count: 9'd511, in_count: 9'd511, default: '0};
    push_item(it, 0);
    push_item(it, 0);
    push_request(0, 2, 2);
    push_request(2, 1, 3);
    it = '{kind: vqdm_pkg::KIND_RECLAIM, device_used_idx: 16'd0, used_id: '1,
           used_len: '1, default: '0};
    push_item(it, 0);
    push_reclaim();
    push_reclaim();
    push_item('{kind: vqdm_pkg::KIND_KICK, default: '0}, 0);
    it = random_item();
    it.kind = KIND_UNDEF;
    push_item(it, 0);
    it = '{kind: vqdm_pkg::KIND_RECLAIM, device_used_idx: '1, used_id: '1, used_len: '1,
           default: '0};
    push_item(it, 0);
    push_item('{kind: vqdm_pkg::KIND_ADD, out_count: 9'd256, in_count: 9'd0,
                default: '0}, 0);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_write(vqdm_pkg::REG_QNUM, 32'hFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (ph)
        1: cfg_write(vqdm_pkg::REG_ENTRIES, 32'd2);
        2: cfg_write(vqdm_pkg::REG_ENTRIES, 32'd4);
        3: cfg_write(vqdm_pkg::REG_ENTRIES, 32'd0);
        4: cfg_write(vqdm_pkg::REG_ENTRIES, 32'h1FF);
        5: cfg_write(vqdm_pkg::REG_ENTRIES, 32'd7);
        6: cfg_write(vqdm_pkg::REG_ENTRIES, 32'd16);
        7: cfg_write(vqdm_pkg::REG_ENTRIES, 32'd256);
        default: ;
      endcase
      cfg_write(vqdm_pkg::REG_QNUM, (ph == 3) ? 32'd0 : $urandom_range(65535));
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_arm = ~hold_arm;  // long receiver hold-off while items keep coming
      end
      push_random_mix(37);
      wait_drained();
      push_random_mix(37);
      wait_drained();
      repeat (20) @(posedge clk);
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/vqdm_pkg.sv
hdl/vqdm_ram.sv
hdl/virtqueue_descriptor_manager_top.sv
dv/testbench.sv
